>>> design/stbs_pkg.sv
package stbs_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // fixed field widths
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 32;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // operation codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_COMPARE_SIGNED = CFG_IDX_W'(1);

    typedef struct packed {
        logic             func;
        logic [IDX_W-1:0] entry_index;
        logic [VAL_W-1:0] item_value;
    } stbs_in_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } stbs_out_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic      valid;
        stbs_out_t data;
    } stbs_res_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_HOLD   = 3'b100
    } stbs_state_t;

endpackage

>>> design/sorted_table_binary_search_top.sv
// a search result is registered in the output register after acceptance, with one table
//   probe per cycle through the single read port of the table memory
// a search holds off new words until its result reaches the output register; writes do not
// an empty table answers not found with no probe, at the accepting edge if the output is free
// reset: synchronous, active low; clears the sequencer, output valid and both config registers;
//   table contents are undefined until written
module sorted_table_binary_search_top
    import stbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  stbs_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output stbs_out_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [COUNT_W-1:0]   entry_count_reg, entry_count_next;
    logic                 compare_signed_reg, compare_signed_next;
    logic                 m_valid_reg, m_valid_next;
    stbs_out_t            m_data_reg, m_data_next;

    logic                 in_word;
    logic                 start;
    logic                 wr_en;
    logic                 idle;
    logic                 out_free;
    logic [ADDR_W-1:0]    rd_addr;
    logic [KEY_WIDTH-1:0] rd_data;
    stbs_res_t            res;

    assign cfg_ready = 1'b1;
    assign s_ready   = idle;
    assign in_word   = s_valid && s_ready;
    assign start     = in_word && (s_data.func == FUNC_SEARCH);
    assign wr_en     = in_word && (s_data.func == FUNC_WRITE)
                       && (32'(s_data.entry_index) < TABLE_DEPTH);
    assign out_free  = !m_valid_reg || m_ready;

    // configuration registers
    always_comb begin
        entry_count_next    = entry_count_reg;
        compare_signed_next = compare_signed_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ENTRY_COUNT:    entry_count_next    = cfg_data[COUNT_W-1:0];
                REG_COMPARE_SIGNED: compare_signed_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res.valid && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = res.data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg    <= '0;
            compare_signed_reg <= 1'b0;
            m_valid_reg        <= 1'b0;
        end else begin
            entry_count_reg    <= entry_count_next;
            compare_signed_reg <= compare_signed_next;
            m_valid_reg        <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // key table
    stbs_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (ADDR_W'(s_data.entry_index)),
        .wdata (KEY_WIDTH'(s_data.item_value)),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // probe sequencer with shared compare unit
    stbs_ctrl u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start),
        .search_value   (s_data.item_value),
        .entry_count    (entry_count_reg),
        .compare_signed (compare_signed_reg),
        .idle           (idle),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .out_free       (out_free),
        .res            (res)
    );

endmodule

>>> design/stbs_ram.sv
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/stbs_ctrl.sv
module stbs_ctrl
    import stbs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [VAL_W-1:0]     search_value,
    input  logic [COUNT_W-1:0]   entry_count,
    input  logic                 compare_signed,
    output logic                 idle,
    output logic [ADDR_W-1:0]    rd_addr,
    input  logic [KEY_WIDTH-1:0] rd_data,
    input  logic                 out_free,
    output stbs_res_t            res
);

    localparam logic [KEY_WIDTH-1:0] SIGN_BIT = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

    stbs_state_t state_reg, state_next;
    logic [CNT_W-1:0]     lower_reg, lower_next;
    logic [CNT_W-1:0]     upper_reg, upper_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic                 sgn_reg, sgn_next;
    logic                 hold_found_reg, hold_found_next;
    logic [IDX_W-1:0]     hold_index_reg, hold_index_next;

    logic [CNT_W-1:0]     cnt_sat;
    logic [KEY_WIDTH-1:0] entry_ord;
    logic                 hit;
    logic                 less;
    logic [CNT_W-1:0]     nl;
    logic [CNT_W-1:0]     nu;
    logic [CNT_W:0]       sum;
    logic [CNT_W-1:0]     npos;

    // saturate the count at the table depth
    assign cnt_sat = (32'(entry_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                      : CNT_W'(entry_count);

    // shared compare unit: probe entry against the stored key
    assign entry_ord = rd_data ^ (sgn_reg ? SIGN_BIT : '0);
    assign hit       = (entry_ord == key_reg);
    assign less      = (key_reg < entry_ord);
    assign nl        = less ? lower_reg : pos_reg + CNT_W'(1);
    assign nu        = less ? pos_reg : upper_reg;
    assign sum       = {1'b0, nl} + {1'b0, nu};
    assign npos      = sum[CNT_W:1];

    assign idle = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next      = state_reg;
        lower_next      = lower_reg;
        upper_next      = upper_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        sgn_next        = sgn_reg;
        hold_found_next = hold_found_reg;
        hold_index_next = hold_index_reg;
        rd_addr         = ADDR_W'(npos);
        res             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = ADDR_W'(cnt_sat >> 1);
                if (start) begin
                    key_next   = KEY_WIDTH'(search_value)
                                 ^ (compare_signed ? SIGN_BIT : '0);
                    sgn_next   = compare_signed;
                    lower_next = '0;
                    upper_next = cnt_sat;
                    pos_next   = cnt_sat >> 1;
                    if (cnt_sat == '0) begin
                        // empty table: not found at once
                        res.valid       = 1'b1;
                        hold_found_next = 1'b0;
                        hold_index_next = '0;
                        state_next      = out_free ? ST_IDLE : ST_HOLD;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                lower_next = nl;
                upper_next = nu;
                pos_next   = npos;
                if (hit || (nl >= nu)) begin
                    res.valid             = 1'b1;
                    res.data.found        = hit;
                    res.data.match_index  = hit ? IDX_W'(pos_reg) : '0;
                    hold_found_next       = res.data.found;
                    hold_index_next       = res.data.match_index;
                    state_next            = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                res.valid            = 1'b1;
                res.data.found       = hold_found_reg;
                res.data.match_index = hold_index_reg;
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        lower_reg      <= lower_next;
        upper_reg      <= upper_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        sgn_reg        <= sgn_next;
        hold_found_reg <= hold_found_next;
        hold_index_reg <= hold_index_next;
    end

    // window is never empty while probing
    a_window_open: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (lower_reg < upper_reg))
        else $error("search window empty while probing");

    // probe lies inside the window
    a_probe_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH) |-> (pos_reg >= lower_reg && pos_reg < upper_reg))
        else $error("probe outside search window");

    // window shrinks on every probe
    a_window_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEARCH && $past(state_reg == ST_SEARCH)) |->
        ((upper_reg - lower_reg) < $past(upper_reg - lower_reg)))
        else $error("search window did not shrink");

    // a blocked result is parked
    a_park_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !out_free) |=> (state_reg == ST_HOLD))
        else $error("blocked result not held");

    // an empty table never starts probing
    a_empty_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && start && cnt_sat == '0) |=> (state_reg != ST_SEARCH))
        else $error("probe started on empty table");

endmodule

>>> dv/sorted_table_binary_search_top_test.sv
`timescale 1ns / 1ps

module sorted_table_binary_search_top_test;
    import stbs_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    stbs_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    stbs_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // words waiting for the driver, and search answers still owed by the block
    stbs_in_t  pending_words[$];
    stbs_out_t answers_due[$];

    // mirror of the block, updated as words and register writes are accepted
    logic [KEY_WIDTH-1:0] key_store [TABLE_DEPTH];
    logic [COUNT_W-1:0]   live_count = '0;
    logic                 live_signed = 1'b0;

    // table contents and settings as seen by the stimulus when it is queued
    logic [KEY_WIDTH-1:0] plan_store [TABLE_DEPTH];
    int unsigned          plan_count = 0;
    logic                 plan_signed = 1'b0;

    int send_idle_pct = 26;
    int recv_idle_pct = 84;
    int error_count = 0;
    int quiet_cycles = 0;

    sorted_table_binary_search_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // map a key onto an unsigned value with the configured ordering
    function automatic logic [KEY_WIDTH-1:0] order_of(input logic [KEY_WIDTH-1:0] k,
                                                      input logic signed_mode);
        return k ^ {signed_mode, {(KEY_WIDTH-1){1'b0}}};
    endfunction

    // halve the window over the live entries until a probe matches or it empties
    function automatic stbs_out_t lookup_key(input logic [KEY_WIDTH-1:0] key);
        int                   lower;
        int                   upper;
        int                   probe;
        logic [KEY_WIDTH-1:0] want;
        logic [KEY_WIDTH-1:0] held;
        stbs_out_t            answer;
        answer = '0;
        lower = 0;
        upper = (live_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(live_count);
        want = order_of(key, live_signed);
        while (lower < upper) begin
            probe = (lower + upper) / 2;
            held = order_of(key_store[probe], live_signed);
            if (want == held) begin
                answer.found = 1'b1;
                answer.match_index = probe[IDX_W-1:0];
                lower = upper;
            end else if (want < held) begin
                upper = probe;
            end else begin
                lower = probe + 1;
            end
        end
        return answer;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // word source
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data  <= pending_words.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result sink back-pressure
    always @(posedge aclk) begin
        m_ready <= aresetn && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // track accepted words and register writes, check returned answers
    always @(posedge aclk) begin
        stbs_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_ENTRY_COUNT:    live_count = cfg_data[COUNT_W-1:0];
                    REG_COMPARE_SIGNED: live_signed = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_data.func == FUNC_SEARCH)
                    answers_due.push_back(lookup_key(s_data.item_value[KEY_WIDTH-1:0]));
                else
                    key_store[s_data.entry_index] = s_data.item_value[KEY_WIDTH-1:0];
            end
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    report_error($sformatf("unexpected answer found=%0b index=%0d",
                                           m_data.found, m_data.match_index));
                end else begin
                    want = answers_due.pop_front();
                    if (m_data.found !== want.found)
                        report_error($sformatf("found %0b, expected %0b",
                                               m_data.found, want.found));
                    if (m_data.match_index !== want.match_index)
                        report_error($sformatf("match_index %0d, expected %0d",
                                               m_data.match_index, want.match_index));
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic stbs_in_t word_of(input logic func, input logic [IDX_W-1:0] idx,
                                         input logic [VAL_W-1:0] value);
        stbs_in_t w;
        w.func = func;
        w.entry_index = idx;
        w.item_value = value;
        return w;
    endfunction

    task automatic queue_write(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
        plan_store[idx] = value[KEY_WIDTH-1:0];
        pending_words.push_back(word_of(FUNC_WRITE, idx, value));
    endtask

    task automatic queue_search(input logic [VAL_W-1:0] key);
        pending_words.push_back(word_of(FUNC_SEARCH, IDX_W'($urandom), key));
    endtask

    // register write, issued right after a rising edge
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_ENTRY_COUNT:    plan_count = value[COUNT_W-1:0];
            REG_COMPARE_SIGNED: plan_signed = value[0];
            default: ;
        endcase
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold off until every word is taken and every answer is back
    task automatic drain;
        do @(negedge aclk);
        while (pending_words.size() != 0 || s_valid || answers_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // fill the whole table in ascending order for the current key order
    task automatic fill_sorted;
        logic [KEY_WIDTH-1:0] ordered;
        ordered = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i == TABLE_DEPTH - 1)
                ordered = '1;
            else if (i != 0)
                ordered = ordered + $urandom_range(0, 1 << 24);
            queue_write(IDX_W'(i), order_of(ordered, plan_signed));
        end
    endtask

    // mostly searches for stored keys and their neighbors, some writes
    task automatic random_words(input int n);
        int unsigned          limit;
        logic [KEY_WIDTH-1:0] key;
        logic [IDX_W-1:0]     idx;
        longint unsigned      lo_ord;
        longint unsigned      hi_ord;
        longint unsigned      pick;
        int                   roll;
        for (int i = 0; i < n; i++) begin
            limit = (plan_count > TABLE_DEPTH) ? TABLE_DEPTH : plan_count;
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                idx = IDX_W'($urandom);
                lo_ord = (idx == 0) ? 0 : order_of(plan_store[idx - 1], plan_signed);
                hi_ord = (idx == TABLE_DEPTH - 1) ? 64'hFFFF_FFFF :
                         order_of(plan_store[idx + 1], plan_signed);
                if ($urandom_range(0, 9) < 7 && lo_ord <= hi_ord) begin
                    pick = lo_ord + ({$urandom, $urandom} % (hi_ord - lo_ord + 1));
                    key = order_of(pick[KEY_WIDTH-1:0], plan_signed);
                end else begin
                    key = $urandom;
                end
                queue_write(idx, key);
            end else begin
                roll = $urandom_range(0, 99);
                if (limit != 0 && roll < 80) begin
                    key = plan_store[$urandom_range(0, limit - 1)];
                    if (roll >= 60)
                        key = $urandom_range(0, 1) ? key + 1 : key - 1;
                end else begin
                    key = $urandom;
                end
                queue_search(key);
            end
        end
    endtask

    // stimulus sequence
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 26;
        recv_idle_pct = 84;

        // empty table, then load an unsigned-sorted table
        queue_search('0);
        queue_search('1);
        fill_sorted();
        drain();

        set_reg(REG_COMPARE_SIGNED, 0);
        set_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
        queue_search(plan_store[0]);
        queue_search(plan_store[TABLE_DEPTH - 1]);
        queue_search(plan_store[TABLE_DEPTH / 2]);
        queue_search(plan_store[TABLE_DEPTH / 2 - 1]);
        queue_search(plan_store[64] + 1);
        random_words(40);
        // let everything come back before sending more
        drain();
        random_words(40);
        drain();

        // single entry
        set_reg(REG_ENTRY_COUNT, 1);
        queue_search(plan_store[0]);
        queue_search(plan_store[1]);
        drain();

        // count above depth saturates
        set_reg(REG_ENTRY_COUNT, (1 << COUNT_W) - 1);
        queue_search(plan_store[TABLE_DEPTH - 1]);
        queue_search(plan_store[0]);
        random_words(10);
        drain();

        // sender idles heavily, receiver lightly; signed order
        send_idle_pct = 84;
        recv_idle_pct = 26;
        set_reg(REG_COMPARE_SIGNED, 1);
        set_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
        fill_sorted();
        queue_search({1'b1, {(VAL_W-1){1'b0}}});
        queue_search({1'b0, {(VAL_W-1){1'b1}}});
        random_words(40);
        drain();

        set_reg(REG_ENTRY_COUNT, $urandom_range(2, TABLE_DEPTH - 1));
        random_words(20);
        drain();

        // no idling; signed-sorted table searched in unsigned order
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_reg(REG_COMPARE_SIGNED, 0);
        set_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
        random_words(20);
        drain();

        set_reg(REG_COMPARE_SIGNED, 1);
        set_reg(REG_ENTRY_COUNT, $urandom_range(1, TABLE_DEPTH));
        random_words(20);
        drain();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
